// ===== design/sdiv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdiv_pkg
// Shared types and constants for the signed 128-bit divider.
// ----------------------------------------------------------------------------
package sdiv_pkg;

  localparam int DATA_W  = 128;
  localparam int HALF_W  = DATA_W / 2;
  localparam int CELL_W  = 16;
  localparam int N_CELLS = DATA_W / CELL_W;
  localparam int CNT_W   = $clog2(DATA_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } sdiv_state_t;

  // controls broadcast to every cell of the row
  typedef struct packed {
    logic load;
    logic step;
  } sdiv_cell_ctrl_t;

  function automatic logic [DATA_W-1:0] neg128(input logic [DATA_W-1:0] v);
    neg128 = ~v + DATA_W'(1);
  endfunction

endpackage

// ===== design/sdiv_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdiv_in_if / sdiv_out_if
// Valid/ready channels carrying operands and results of the divider.
// ----------------------------------------------------------------------------
interface sdiv_in_if;
  logic               valid;
  logic               ready;
  logic        [63:0] dividend_low;
  logic signed [63:0] dividend_high;
  logic        [63:0] divisor_low;
  logic signed [63:0] divisor_high;

  modport source (output valid, dividend_low, dividend_high, divisor_low, divisor_high,
                  input ready);
  modport sink   (input valid, dividend_low, dividend_high, divisor_low, divisor_high,
                  output ready);
endinterface

interface sdiv_out_if;
  logic               valid;
  logic               ready;
  logic        [63:0] quotient_low;
  logic signed [63:0] quotient_high;
  logic        [63:0] remainder_low;
  logic signed [63:0] remainder_high;

  modport source (output valid, quotient_low, quotient_high, remainder_low, remainder_high,
                  input ready);
  modport sink   (input valid, quotient_low, quotient_high, remainder_low, remainder_high,
                  output ready);
endinterface

// ===== design/sdiv_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdiv_cell
// One slice of the shift-subtract datapath: remainder, quotient and divisor.
// ----------------------------------------------------------------------------
module sdiv_cell (
  input  logic                            clk,
  input  sdiv_pkg::sdiv_cell_ctrl_t       ctrl,
  input  logic [sdiv_pkg::CELL_W-1:0]     load_rem,
  input  logic [sdiv_pkg::CELL_W-1:0]     load_quo,
  input  logic [sdiv_pkg::CELL_W-1:0]     load_div,
  input  logic                            rem_in,
  input  logic                            quo_in,
  input  logic                            borrow_in,
  input  logic                            take,
  output logic                            rem_msb,
  output logic                            quo_msb,
  output logic                            borrow_out,
  output logic [sdiv_pkg::CELL_W-1:0]     rem_o,
  output logic [sdiv_pkg::CELL_W-1:0]     quo_o
);
  import sdiv_pkg::*;

  logic [CELL_W-1:0] rem_r, rem_nxt;
  logic [CELL_W-1:0] quo_r, quo_nxt;
  logic [CELL_W-1:0] div_r;
  logic [CELL_W-1:0] shifted;
  logic [CELL_W:0]   diff;

  assign shifted = {rem_r[CELL_W-2:0], rem_in};
  // slice of the trial subtract, borrow ripples up the row
  assign diff    = {1'b0, shifted} - {1'b0, div_r} - (CELL_W + 1)'(borrow_in);

  assign borrow_out = diff[CELL_W];
  assign rem_msb    = rem_r[CELL_W-1];
  assign quo_msb    = quo_r[CELL_W-1];
  assign rem_o      = rem_r;
  assign quo_o      = quo_r;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (ctrl.load) begin
      rem_nxt = load_rem;
      quo_nxt = load_quo;
    end else if (ctrl.step) begin
      rem_nxt = take ? diff[CELL_W-1:0] : shifted;
      quo_nxt = {quo_r[CELL_W-2:0], quo_in};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (ctrl.load) begin
      div_r <= load_div;
    end
  end

endmodule

// ===== design/signed_128bit_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_128bit_divider
// Signed 128-bit divide with truncated quotient and dividend-signed remainder.
// ----------------------------------------------------------------------------
// in_req carries one request: dividend and divisor, each as a signed upper and
// an unsigned lower 64-bit half. out_res returns quotient and remainder in the
// same split form, one result per request, in order.
// A request is taken only while the divider is idle. Operands are reduced to
// magnitudes on acceptance, then a row of eight 16-bit cells retires one
// quotient bit per cycle in ST_RUN; the borrow of the trial subtract ripples
// through the row and sets every step. Signs are restored as the result
// enters the output register; a zero divisor skips the steps. The next request
// waits until the current result has moved into the output register.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls with a result still held, the
// divider waits with its own result until the register frees.
// rst_n (synchronous, active low) empties the divider and the output register.
// ----------------------------------------------------------------------------
module signed_128bit_divider (
  input  logic   clk,
  input  logic   rst_n,
  sdiv_in_if.sink    in_req,
  sdiv_out_if.source out_res
);
  import sdiv_pkg::*;

  sdiv_state_t       state_r, state_nxt;
  sdiv_cell_ctrl_t   ctrl;
  logic              out_load;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              q_neg_r, n_neg_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_q_r, out_rem_r;

  logic [DATA_W-1:0] n_in, d_in, n_mag, d_mag;
  logic              n_neg, d_neg, d_zero;
  logic [DATA_W-1:0] load_rem, load_quo;
  logic [DATA_W-1:0] rem_all, quo_all;
  logic [N_CELLS-1:0] rem_msb, quo_msb, borrow;
  logic              take;
  logic              accept, out_free;

  assign n_in   = {in_req.dividend_high, in_req.dividend_low};
  assign d_in   = {in_req.divisor_high, in_req.divisor_low};
  assign n_neg  = n_in[DATA_W-1];
  assign d_neg  = d_in[DATA_W-1];
  assign d_zero = (d_in == '0);
  assign n_mag  = n_neg ? neg128(n_in) : n_in;
  assign d_mag  = d_neg ? neg128(d_in) : d_in;

  // zero divisor skips the steps: remainder holds the dividend, quotient zero
  assign load_rem = d_zero ? n_mag : '0;
  assign load_quo = d_zero ? '0 : n_mag;

  assign accept   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign take     = !borrow[N_CELLS-1];

  genvar g;
  generate
    for (g = 0; g < N_CELLS; g++) begin : g_cell
      logic rem_in_w, quo_in_w, borrow_in_w;
      if (g == 0) begin : g_first
        assign rem_in_w    = quo_msb[N_CELLS-1];
        assign quo_in_w    = take;
        assign borrow_in_w = 1'b0;
      end else begin : g_rest
        assign rem_in_w    = rem_msb[g-1];
        assign quo_in_w    = quo_msb[g-1];
        assign borrow_in_w = borrow[g-1];
      end
      sdiv_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .load_rem   (load_rem[g*CELL_W +: CELL_W]),
        .load_quo   (load_quo[g*CELL_W +: CELL_W]),
        .load_div   (d_mag[g*CELL_W +: CELL_W]),
        .rem_in     (rem_in_w),
        .quo_in     (quo_in_w),
        .borrow_in  (borrow_in_w),
        .take       (take),
        .rem_msb    (rem_msb[g]),
        .quo_msb    (quo_msb[g]),
        .borrow_out (borrow[g]),
        .rem_o      (rem_all[g*CELL_W +: CELL_W]),
        .quo_o      (quo_all[g*CELL_W +: CELL_W])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = d_zero ? ST_DONE : ST_RUN;
          cnt_nxt   = CNT_W'(DATA_W - 1);
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_req.ready = 1'b0;
    ctrl.load    = 1'b0;
    ctrl.step    = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // no request is taken while reset is held
        in_req.ready = rst_n;
        ctrl.load    = in_req.valid && rst_n;
      end
      ST_RUN:  ctrl.step = 1'b1;
      ST_DONE: out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_neg_r <= n_neg ^ d_neg;
      n_neg_r <= n_neg;
    end
    if (out_load) begin
      out_q_r   <= q_neg_r ? neg128(quo_all) : quo_all;
      out_rem_r <= n_neg_r ? neg128(rem_all) : rem_all;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.quotient_low   = out_q_r[HALF_W-1:0];
  assign out_res.quotient_high  = signed'(out_q_r[DATA_W-1:HALF_W]);
  assign out_res.remainder_low  = out_rem_r[HALF_W-1:0];
  assign out_res.remainder_high = signed'(out_rem_r[DATA_W-1:HALF_W]);

endmodule
